// ----- rtl/core/crbm_pkg.sv -----
// Shared types and constants for the cartridge bank mapper.
`default_nettype none
package crbm_pkg;

  localparam logic [1:0] OP_READ    = 2'd0;
  localparam logic [1:0] OP_WRITE   = 2'd1;
  localparam logic [1:0] OP_BOOT_WR = 2'd2;
  localparam logic [1:0] OP_UNUSED  = 2'd3;

  localparam logic [1:0] TGT_NONE = 2'd0;
  localparam logic [1:0] TGT_BOOT = 2'd1;
  localparam logic [1:0] TGT_ROM  = 2'd2;
  localparam logic [1:0] TGT_RAM  = 2'd3;

  localparam logic [1:0] CFG_CART_LOADED = 2'd0;
  localparam logic [1:0] CFG_NO_MAPPER   = 2'd1;

  // Mapper register window, address bits 14:13 below 0x8000
  localparam logic [1:0] WIN_RAM_EN   = 2'd0;
  localparam logic [1:0] WIN_ROM_BANK = 2'd1;
  localparam logic [1:0] WIN_RAM_BANK = 2'd2;
  localparam logic [1:0] WIN_MODE     = 2'd3;

  localparam logic [3:0] RAM_EN_KEY = 4'hA;
  localparam logic [2:0] EXT_RAM_TOP3 = 3'b101;

  typedef struct packed {
    logic [1:0]  operation;
    logic [15:0] address;
    logic [7:0]  data;
  } crbm_in_t;

  typedef struct packed {
    logic [1:0]  target;
    logic [20:0] phys_address;
    logic        write_allowed;
    logic        boot_active;
  } crbm_out_t;

  typedef struct packed {
    logic [1:0] index;
    logic [7:0] value;
  } crbm_cfg_t;

endpackage
`default_nettype wire

// ----- rtl/core/crbm_stream_if.sv -----
// Valid/ready channel carrying one payload per transfer.
`default_nettype none
interface crbm_stream_if #(parameter type payload_t = logic);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface
`default_nettype wire

// ----- rtl/core/cartridge_rom_ram_bank_mapper.sv -----
// Cartridge ROM/RAM bank mapper: bus access translation and mapper registers.
// Usage:
//   in_if  : one CPU bus access per transfer (operation, address, data).
//   out_if : one result per access (target, phys_address, write_allowed,
//            boot_active), in access order.
//   cfg_if : register writes (index 0 cart_loaded, 1 no-mapper flag),
//            always ready; write only while no access is in flight.
// Each access taken is registered into the output register and shows
// there in the next cycle. Throughput is one access per cycle while the
// receiver keeps up, set by the single output register; mapper state
// updates as the access is taken, so the following access sees it.
// When the receiver stalls, the result holds and in_if.ready drops once the
// output register is full; it rises again in the cycle the result leaves.
// Reset (rst_n low, synchronous) clears the output valid flag and sets
// cart_loaded 0, no-mapper 1, RAM disabled, banks 0, mode 0 and the
// boot overlay on.
`default_nettype none
module cartridge_rom_ram_bank_mapper #(
  parameter int unsigned BOOT_ROM_BYTES = 256
) (
  input  logic          clk,
  input  logic          rst_n,
  crbm_stream_if.sink   in_if,
  crbm_stream_if.source out_if,
  crbm_stream_if.sink   cfg_if
);
  import crbm_pkg::*;

  localparam logic [16:0] BOOT_LIMIT = 17'(BOOT_ROM_BYTES);

  logic        cart_loaded_r, cart_loaded_nxt;
  logic        nomap_r, nomap_nxt;
  logic        ram_en_r, ram_en_nxt;
  logic [4:0]  rom_bank_r, rom_bank_nxt;
  logic [1:0]  ram_bank_r, ram_bank_nxt;
  logic        mode_r, mode_nxt;
  logic        boot_r, boot_nxt;
  logic        out_valid_r, out_valid_nxt;
  crbm_out_t   out_data_r, res;

  logic        in_acc, cfg_acc;
  crbm_in_t    acc;
  logic [4:0]  bank_low;
  logic [6:0]  sw_bank;
  logic [1:0]  ext_bank;

  assign in_if.ready  = !out_valid_r || out_if.ready;
  assign cfg_if.ready = 1'b1;
  assign in_acc  = in_if.valid && in_if.ready;
  assign cfg_acc = cfg_if.valid && cfg_if.ready;
  assign acc     = in_if.payload;

  assign out_if.valid   = out_valid_r;
  assign out_if.payload = out_data_r;

  assign bank_low = (rom_bank_r == 5'd0) ? 5'd1 : rom_bank_r;
  assign sw_bank  = {(mode_r ? ram_bank_r : 2'b00), bank_low};
  assign ext_bank = nomap_r ? 2'b00 : ram_bank_r;

  always_comb begin
    cart_loaded_nxt = cart_loaded_r;
    nomap_nxt       = nomap_r;
    if (cfg_acc) begin
      case (cfg_if.payload.index)
        CFG_CART_LOADED: cart_loaded_nxt = cfg_if.payload.value[0];
        CFG_NO_MAPPER:   nomap_nxt       = cfg_if.payload.value[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    ram_en_nxt   = ram_en_r;
    rom_bank_nxt = rom_bank_r;
    ram_bank_nxt = ram_bank_r;
    mode_nxt     = mode_r;
    boot_nxt     = boot_r;
    res          = '0;
    case (acc.operation)
      OP_BOOT_WR: begin
        if (acc.data != 8'd0) boot_nxt = 1'b0;
      end
      OP_READ, OP_WRITE: begin
        if (!acc.address[15]) begin
          if (acc.operation == OP_WRITE) begin
            if (cart_loaded_r) begin
              case (acc.address[14:13])
                WIN_RAM_EN:   ram_en_nxt   = (acc.data[3:0] == RAM_EN_KEY);
                WIN_ROM_BANK: rom_bank_nxt = acc.data[4:0];
                WIN_RAM_BANK: if (!nomap_r) ram_bank_nxt = acc.data[1:0];
                WIN_MODE:     mode_nxt     = acc.data[0];
                default: ;
              endcase
            end
          end else if (boot_r && ({1'b0, acc.address} < BOOT_LIMIT)) begin
            res.target       = TGT_BOOT;
            res.phys_address = {5'd0, acc.address};
          end else if (!acc.address[14]) begin
            res.target       = TGT_ROM;
            res.phys_address = {5'd0, acc.address};
          end else begin
            res.target       = TGT_ROM;
            res.phys_address = {sw_bank, acc.address[13:0]};
          end
        end else if (acc.address[15:13] == EXT_RAM_TOP3) begin
          res.target        = TGT_RAM;
          res.phys_address  = {6'd0, ext_bank, acc.address[12:0]};
          res.write_allowed = (acc.operation == OP_WRITE) && ram_en_r;
        end
      end
      default: ;
    endcase
    res.boot_active = boot_nxt;
  end

  assign out_valid_nxt = in_acc || (out_valid_r && !out_if.ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cart_loaded_r <= 1'b0;
      nomap_r       <= 1'b1;
      ram_en_r      <= 1'b0;
      rom_bank_r    <= 5'd0;
      ram_bank_r    <= 2'd0;
      mode_r        <= 1'b0;
      boot_r        <= 1'b1;
      out_valid_r   <= 1'b0;
    end else begin
      cart_loaded_r <= cart_loaded_nxt;
      nomap_r       <= nomap_nxt;
      out_valid_r   <= out_valid_nxt;
      if (in_acc) begin
        ram_en_r   <= ram_en_nxt;
        rom_bank_r <= rom_bank_nxt;
        ram_bank_r <= ram_bank_nxt;
        mode_r     <= mode_nxt;
        boot_r     <= boot_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      out_data_r <= res;
    end
  end

`ifndef SYNTHESIS
  a_boot_stays_off: assert property (@(posedge clk) disable iff (!rst_n)
    !boot_r |=> !boot_r)
    else $error("boot overlay re-enabled without reset");

  a_accept_fills_out: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> out_valid_r)
    else $error("accepted transfer produced no result");

  a_none_zero_addr: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_data_r.target == TGT_NONE) |-> out_data_r.phys_address == 21'd0)
    else $error("no-target result with nonzero address");

  a_wr_only_ram: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_data_r.write_allowed) |-> out_data_r.target == TGT_RAM)
    else $error("write allowed outside external RAM");

  a_boot_tgt_active: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_data_r.target == TGT_BOOT) |-> out_data_r.boot_active)
    else $error("boot ROM target while overlay is off");
`endif

endmodule
`default_nettype wire
